// ===== sv/fixed_slot_free_list_allocator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Checked on every rising edge, off while reset is asserted.
`define FSLA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fsla assertion failed");

// Checked on every rising edge, reset included.
`define FSLA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fsla assertion failed");

`endif

// ===== sv/fsla_pkg.sv =====
`timescale 1ns / 1ps
package fsla_pkg;

  localparam int unsigned REL_W      = 10;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned OFF_W      = 26;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]  COUNT_MAX        = 11'h7FF;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET   = 11'd0;
  localparam logic [SIZE_W-1:0] SLOT_BYTES_RESET = 16'd1;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY   = 1'b0,
    CFG_SLOT_BYTES = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LINK = 1'b1
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_index;
    logic [OFF_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  live_count;
  } rsp_t;

endpackage

// ===== sv/fsla_ifs.sv =====
`timescale 1ns / 1ps
interface fsla_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [fsla_pkg::REL_W-1:0]     release_index;

  modport source (output valid, operation, release_index, input ready);
  modport sink   (input valid, operation, release_index, output ready);
endinterface

interface fsla_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [fsla_pkg::SLOT_W-1:0]    slot_index;
  logic [fsla_pkg::OFF_W-1:0]     byte_offset;
  logic [fsla_pkg::CNT_W-1:0]     live_count;

  modport source (output valid, ok, slot_index, byte_offset, live_count, input ready);
  modport sink   (input valid, ok, slot_index, byte_offset, live_count, output ready);
endinterface

interface fsla_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fsla_pkg::CFG_IDX_W-1:0]  index;
  logic [fsla_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fsla_link_ram.sv =====
`timescale 1ns / 1ps
module fsla_link_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fsla_rsp_buf.sv =====
`timescale 1ns / 1ps
module fsla_rsp_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fsla_pkg::rsp_t    data_i,
  output logic              space_o,
  fsla_rsp_if.source        rsp_o
);

  fsla_pkg::rsp_t out_d, out_q, skid_d, skid_q;
  logic           out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic           pop;

  assign pop = out_vld_q && rsp_o.ready;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_d     = data_i;
        skid_vld_d = push_i;
      end else begin
        out_d     = data_i;
        out_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = data_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o           = !skid_vld_q;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.ok          = out_q.ok;
  assign rsp_o.slot_index  = out_q.slot_index;
  assign rsp_o.byte_offset = out_q.byte_offset;
  assign rsp_o.live_count  = out_q.live_count;

endmodule

// ===== sv/fixed_slot_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Fixed-size slot allocator with an intrusive free list.
// req_i: one word per request, operation 0 = allocate, 1 = release of release_index.
// rsp_o: one word per request, in request order: ok, slot_index, byte_offset
//   (slot_index * slot size in bytes, 26 bits) and live_count after the request.
// cfg_i: register writes, index 0 = capacity, index 1 = slot size in bytes; always
//   ready; the user writes it only while no request is outstanding (unenforced).
// Path: release, bump allocate and failed requests enter the output buffer
//   from the accepting cycle; an allocate popping the free list first goes
//   through ST_LINK, as the next link comes from the synchronous link RAM.
// Throughput: one request per cycle for releases and bump allocates while
//   the output buffer has space; free-list allocates hold requests off in ST_LINK.
// Reset: free list empty, bump pointer and live count zero, capacity 0,
//   slot size 1. The link RAM is not cleared; no request waits on it.
// Output stall: a two-word output buffer keeps accepting while a result waits;
//   req_i.ready drops while both words are held and during the link read cycle.
module fixed_slot_free_list_allocator #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsla_req_if.sink    req_i,
  fsla_cfg_if.sink    cfg_i,
  fsla_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned HW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned LW = (HW > fsla_pkg::CAP_W) ? HW : fsla_pkg::CAP_W;
  localparam int unsigned PW = IW + fsla_pkg::SIZE_W;

  fsla_pkg::state_e               state_d, state_q;
  logic [HW-1:0]                  head_d, head_q;
  logic [LW-1:0]                  bump_d, bump_q;
  logic [fsla_pkg::CNT_W-1:0]     cnt_d, cnt_q;
  logic [fsla_pkg::CAP_W-1:0]     cap_d, cap_q;
  logic [fsla_pkg::SIZE_W-1:0]    size_d, size_q;

  logic          accept, space, head_empty, rel_ok, is_rel, push;
  logic [LW-1:0] cap_ext, limit;
  logic [31:0]   rel_ext, idx_ext;
  logic [IW-1:0] rel_idx, res_idx;
  logic          res_ok;
  logic [PW-1:0] prod;
  logic [63:0]   prod_ext;
  fsla_pkg::rsp_t res;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [HW-1:0] mem_wdata, mem_rdata;

  assign req_i.ready = (state_q == fsla_pkg::ST_IDLE) && space;
  assign accept      = req_i.valid && req_i.ready;
  assign is_rel      = (fsla_pkg::op_e'(req_i.operation) == fsla_pkg::OP_RELEASE);
  assign head_empty  = (head_q >= HW'(MAX_SLOTS));
  assign rel_ext     = 32'(req_i.release_index);
  assign rel_ok      = (rel_ext < 32'(MAX_SLOTS));
  assign rel_idx     = rel_ext[IW-1:0];
  assign cap_ext     = LW'(cap_q);
  assign limit       = (cap_ext > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : cap_ext;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsla_pkg::ST_IDLE: begin
        if (accept && !is_rel && !head_empty) begin
          state_d = fsla_pkg::ST_LINK;
        end
      end
      fsla_pkg::ST_LINK: begin
        state_d = fsla_pkg::ST_IDLE;
      end
      default: state_d = fsla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    bump_d    = bump_q;
    cnt_d     = cnt_q;
    push      = 1'b0;
    res_ok    = 1'b0;
    res_idx   = '0;
    mem_we    = 1'b0;
    mem_waddr = rel_idx;
    mem_wdata = head_q;
    mem_re    = 1'b0;
    mem_raddr = head_q[IW-1:0];
    unique case (state_q)
      fsla_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_rel) begin
            push = 1'b1;
            if (rel_ok) begin
              mem_we  = 1'b1;
              head_d  = HW'(rel_idx);
              cnt_d   = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
              res_ok  = 1'b1;
              res_idx = rel_idx;
            end
          end else if (!head_empty) begin
            mem_re = 1'b1;
          end else begin
            push = 1'b1;
            if (bump_q < limit) begin
              bump_d  = bump_q + 1'b1;
              cnt_d   = (cnt_q == fsla_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
              res_ok  = 1'b1;
              res_idx = bump_q[IW-1:0];
            end
          end
        end
      end
      fsla_pkg::ST_LINK: begin
        push    = 1'b1;
        head_d  = mem_rdata;
        cnt_d   = (cnt_q == fsla_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
        res_ok  = 1'b1;
        res_idx = head_q[IW-1:0];
      end
      default: ;
    endcase
  end

  assign prod     = PW'(res_idx) * PW'(size_q);
  assign prod_ext = 64'(prod);
  assign idx_ext  = 32'(res_idx);

  always_comb begin
    res.ok          = res_ok;
    res.slot_index  = idx_ext[fsla_pkg::SLOT_W-1:0];
    res.byte_offset = prod_ext[fsla_pkg::OFF_W-1:0];
    res.live_count  = cnt_d;
  end

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cap_d  = cap_q;
    size_d = size_q;
    if (cfg_i.valid) begin
      unique case (fsla_pkg::cfg_reg_e'(cfg_i.index))
        fsla_pkg::CFG_CAPACITY:   cap_d  = cfg_i.data[fsla_pkg::CAP_W-1:0];
        fsla_pkg::CFG_SLOT_BYTES: size_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsla_pkg::ST_IDLE;
      head_q  <= HW'(MAX_SLOTS);
      bump_q  <= '0;
      cnt_q   <= '0;
      cap_q   <= fsla_pkg::CAPACITY_RESET;
      size_q  <= fsla_pkg::SLOT_BYTES_RESET;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      bump_q  <= bump_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      size_q  <= size_d;
    end
  end

  fsla_link_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (IW),
    .DW    (HW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fsla_rsp_buf u_rsp_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .space_o (space),
    .rsp_o   (rsp_o)
  );

endmodule

// ===== sv/fsla_checker.sv =====
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_assert.svh"
module fsla_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          rsp_ok_i,
  input logic [fsla_pkg::SLOT_W-1:0]   rsp_slot_index_i,
  input logic [fsla_pkg::OFF_W-1:0]    rsp_byte_offset_i,
  input logic [fsla_pkg::CNT_W-1:0]    rsp_live_count_i
);

  logic       req_acc, rsp_acc;
  logic [2:0] pend_d, pend_q;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (req_acc && !rsp_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (rsp_acc && !req_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // at most two words outstanding: output buffer, or one buffered word and a link read
  `FSLA_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q <= 3'd2)
  // no word leaves without a request behind it
  `FSLA_ASSERT(a_no_extra_rsp, clk_i, rst_ni, rsp_acc |-> pend_q != 3'd0)
  `FSLA_ASSERT(a_fail_zero, clk_i, rst_ni,
    (rsp_valid_i && !rsp_ok_i) |-> (rsp_slot_index_i == '0 && rsp_byte_offset_i == '0))
  `FSLA_ASSERT_ALWAYS(a_rsp_hold, clk_i,
    (rst_ni && rsp_valid_i && !rsp_ready_i) |=> (!rst_ni || (rsp_valid_i &&
      $stable(rsp_ok_i) && $stable(rsp_slot_index_i) && $stable(rsp_live_count_i))))

endmodule

bind fixed_slot_free_list_allocator fsla_checker u_fsla_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_ok_i          (rsp_o.ok),
  .rsp_slot_index_i  (rsp_o.slot_index),
  .rsp_byte_offset_i (rsp_o.byte_offset),
  .rsp_live_count_i  (rsp_o.live_count)
);
